@@ src/elev_pkg.sv @@
// Shared types and constants for the elevator up-then-down sweep unit.
package elev_pkg;

   localparam int TOP_FLOOR = 10;
   localparam int NUM_FLOORS = TOP_FLOOR + 1;
   localparam int FLOOR_W = 4;
   localparam int CNT_W = 2;
   localparam int TOTAL_W = $clog2(2 * NUM_FLOORS * 3 + 1);

   localparam logic [FLOOR_W-1:0] TOP_FLOOR_V = FLOOR_W'(TOP_FLOOR);
   localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   typedef enum logic [1:0] {
      EV_UP = 2'd0,
      EV_DOWN = 2'd1,
      EV_ARRIVE = 2'd2
   } event_type;

   // Command to the pending stop store: one floor, one direction.
   typedef struct packed {
      logic [FLOOR_W-1:0] idx;
      logic down;
      logic inc;
      logic dec;
   } stop_cmd_type;

endpackage

@@ src/elev_stop_store.sv @@
// Pending stop counts per floor and direction, with one shared access index.
module elev_stop_store (
   input logic clock,
   input logic reset,
   input elev_pkg::stop_cmd_type cmd,
   output logic [elev_pkg::CNT_W-1:0] cnt
);

   logic [elev_pkg::CNT_W-1:0] up_ff [elev_pkg::NUM_FLOORS];
   logic [elev_pkg::CNT_W-1:0] down_ff [elev_pkg::NUM_FLOORS];
   logic [elev_pkg::CNT_W-1:0] cnt_in;

   assign cnt = cmd.down ? down_ff[cmd.idx] : up_ff[cmd.idx];

   // Increments saturate; decrements are only issued on a nonzero count.
   always_comb begin
      cnt_in = cnt;
      if (cmd.inc && cnt != elev_pkg::COUNT_MAX) begin
         cnt_in = cnt + elev_pkg::CNT_W'(1);
      end else if (cmd.dec) begin
         cnt_in = cnt - elev_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < elev_pkg::NUM_FLOORS; i++) begin
            up_ff[i] <= '0;
            down_ff[i] <= '0;
         end
      end else if (cmd.inc || cmd.dec) begin
         if (cmd.down) begin
            down_ff[cmd.idx] <= cnt_in;
         end else begin
            up_ff[cmd.idx] <= cnt_in;
         end
      end
   end

endmodule

@@ src/elevator_up_then_down_sweep_unit.sv @@
// Top level of the elevator scan controller: request intake and run sequencer.
// A floor request beat is accepted and then counted in the COUNT state; a
// dropped request or a run with nothing pending ends with the accept.
// A run beat scans the floors upward and then downward, one floor per cycle
// while the floor under the scan pointer has no pending stop, and turns at
// the top; the single car stepper puts out one result per floor moved and
// one per arrival, and a stalled result holds it. The run ends on its last arrival.
// Synchronous active-high reset puts the car at the ground floor and clears all
// pending counts; no result is pending after reset.
module elevator_up_then_down_sweep_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_kind,
   input logic [3:0] req_requested_floor,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_event_res,
   output logic [3:0] rsp_floor_now,
   output logic rsp_sweep_down,
   output logic rsp_last
);

   // IDLE waits for a beat. COUNT bumps the count of the requested floor.
   // SCAN looks at the count of the floor under the scan pointer and moves the
   // pointer on when it is empty. STEP drives the car one floor toward the
   // pointer per result, or emits the arrival once the car is there.
   typedef enum logic [1:0] {
      IDLE,
      COUNT,
      SCAN,
      STEP
   } state_type;

   state_type state_ff;
   logic [elev_pkg::FLOOR_W-1:0] car_ff;
   logic [elev_pkg::FLOOR_W-1:0] idx_ff;
   logic down_ff;
   logic [elev_pkg::TOTAL_W-1:0] total_ff;

   logic rsp_valid_ff;
   elev_pkg::event_type rsp_event_ff;
   logic [elev_pkg::FLOOR_W-1:0] rsp_floor_ff;
   logic rsp_down_ff;
   logic rsp_last_ff;

   elev_pkg::stop_cmd_type cmd;
   logic [elev_pkg::CNT_W-1:0] cnt;
   logic req_take;
   logic slot_free;
   logic load;
   logic arrive;

   assign req_stall = (state_ff != IDLE);
   assign req_take = req_valid && !req_stall;
   // The result register can take a new beat when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // The stepper puts out one result beat in every STEP cycle with room.
   assign load = (state_ff == STEP) && slot_free;
   assign arrive = load && (car_ff == idx_ff);

   // The stop store is addressed by the scan pointer, which also holds the
   // requested floor while a request is being counted.
   always_comb begin
      cmd.idx = idx_ff;
      cmd.down = down_ff;
      cmd.inc = (state_ff == COUNT);
      cmd.dec = arrive;
   end

   elev_stop_store u_stops (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .cnt(cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         car_ff <= '0;
         idx_ff <= '0;
         down_ff <= 1'b0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_take) begin
                  if (req_kind == elev_pkg::KIND_REQUEST) begin
                     // Requests at the car floor or above the top are dropped.
                     if (req_requested_floor <= elev_pkg::TOP_FLOOR_V &&
                         req_requested_floor != car_ff) begin
                        idx_ff <= req_requested_floor;
                        down_ff <= (req_requested_floor < car_ff);
                        state_ff <= COUNT;
                     end
                  end else if (total_ff != '0) begin
                     // A run with nothing pending leaves everything as is.
                     idx_ff <= '0;
                     down_ff <= 1'b0;
                     state_ff <= SCAN;
                  end
               end
            end
            COUNT: begin
               if (cnt != elev_pkg::COUNT_MAX) begin
                  total_ff <= total_ff + elev_pkg::TOTAL_W'(1);
               end
               state_ff <= IDLE;
            end
            SCAN: begin
               if (cnt != '0) begin
                  state_ff <= STEP;
               end else if (!down_ff) begin
                  // The up sweep ends at the top floor and the down sweep
                  // starts there.
                  if (idx_ff == elev_pkg::TOP_FLOOR_V) begin
                     down_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + elev_pkg::FLOOR_W'(1);
                  end
               end else if (idx_ff == '0) begin
                  state_ff <= IDLE;
               end else begin
                  idx_ff <= idx_ff - elev_pkg::FLOOR_W'(1);
               end
            end
            STEP: begin
               if (slot_free) begin
                  rsp_down_ff <= down_ff;
                  if (car_ff < idx_ff) begin
                     car_ff <= car_ff + elev_pkg::FLOOR_W'(1);
                     rsp_floor_ff <= car_ff + elev_pkg::FLOOR_W'(1);
                     rsp_event_ff <= elev_pkg::EV_UP;
                     rsp_last_ff <= 1'b0;
                  end else if (car_ff > idx_ff) begin
                     car_ff <= car_ff - elev_pkg::FLOOR_W'(1);
                     rsp_floor_ff <= car_ff - elev_pkg::FLOOR_W'(1);
                     rsp_event_ff <= elev_pkg::EV_DOWN;
                     rsp_last_ff <= 1'b0;
                  end else begin
                     // Arrival: the store decrements this floor's count. The
                     // running total tells whether this is the run's final beat.
                     rsp_floor_ff <= car_ff;
                     rsp_event_ff <= elev_pkg::EV_ARRIVE;
                     rsp_last_ff <= (total_ff == elev_pkg::TOTAL_W'(1));
                     total_ff <= total_ff - elev_pkg::TOTAL_W'(1);
                     state_ff <= (total_ff == elev_pkg::TOTAL_W'(1)) ? IDLE : SCAN;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_floor_now = rsp_floor_ff;
   assign rsp_sweep_down = rsp_down_ff;
   assign rsp_last = rsp_last_ff;

endmodule

@@ src/elev_chk.sv @@
// Port-level checker for the elevator sweep unit, bound to the top level.
module elev_chk (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [1:0] rsp_event_res,
   input logic [3:0] rsp_floor_now,
   input logic rsp_last
);

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Every run ends on an arrival.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_event_res == elev_pkg::EV_ARRIVE)
      else $error("last flag on a move");

   // The car never leaves the building.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_floor_now <= elev_pkg::TOP_FLOOR_V)
      else $error("car floor above the top floor");

   // While a run still owes beats, its pending beat is not the last one and
   // the sequencer is busy, so the input is held off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken in the middle of a run");

endmodule

bind elevator_up_then_down_sweep_unit elev_chk u_elev_chk (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_event_res(rsp_event_res),
   .rsp_floor_now(rsp_floor_now),
   .rsp_last(rsp_last)
);
